// ----- hdl/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants of the LED strip effect engine
// Register indexes, effect codes, color tables, the queue item type and the divider request and response types.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int MAX_LEDS_DEF = 256;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BRIGHT = 2'd1;
    localparam logic [1:0] CFG_ANGLE  = 2'd2;
    localparam logic [1:0] CFG_COUNT  = 2'd3;

    // effect codes
    localparam logic [3:0] MODE_RED     = 4'd0;
    localparam logic [3:0] MODE_GREEN   = 4'd1;
    localparam logic [3:0] MODE_BLUE    = 4'd2;
    localparam logic [3:0] MODE_RAINBOW = 4'd3;
    localparam logic [3:0] MODE_POLICE  = 4'd4;
    localparam logic [3:0] MODE_BREATH  = 4'd5;
    localparam logic [3:0] MODE_TWO_A   = 4'd6;
    localparam logic [3:0] MODE_TWO_B   = 4'd7;
    localparam logic [3:0] MODE_TWO_C   = 4'd8;
    localparam logic [3:0] MODE_THREE_A = 4'd9;
    localparam logic [3:0] MODE_THREE_B = 4'd10;

    localparam logic [8:0] BRIGHT_FULL = 9'd256;
    localparam logic [8:0] ANGLE_MAX   = 9'd450;
    localparam logic [8:0] ANGLE_ZERO  = 9'd225;

    localparam logic [15:0] TWO_HOLD    = 16'd5000;
    localparam logic [15:0] TWO_FADE    = 16'd2000;
    localparam logic [15:0] THREE_HOLD  = 16'd3000;
    localparam logic [15:0] THREE_FADE  = 16'd1000;
    localparam logic [15:0] THREE_SEG   = 16'd4000;

    // floor(x / d) = (x * M) >> s over the operand ranges used
    localparam logic [9:0]  TWO_MOD_D       = 10'd875;         // 14000 >> 4
    localparam logic [9:0]  THREE_MOD_D     = 10'd375;         // 12000 >> 5
    localparam logic [29:0] TWO_MOD_RECIP   = 30'd314146180;   // ceil(2^38 / 875)
    localparam logic [29:0] THREE_MOD_RECIP = 30'd733007752;   // ceil(2^38 / 375)
    localparam logic [15:0] FADE_RECIP      = 16'd33555;       // ceil(2^22 / 125)
    localparam logic [16:0] DIM_RECIP       = 17'd74566;       // ceil(2^24 / 225)

    localparam logic [6:0] BREATH_LAST = 7'd125;

    localparam logic [7:0] BREATH_TBL [0:125] = '{
        8'd127, 8'd133, 8'd140, 8'd146, 8'd152, 8'd159, 8'd165, 8'd171, 8'd177, 8'd182,
        8'd188, 8'd194, 8'd199, 8'd204, 8'd209, 8'd214, 8'd218, 8'd223, 8'd227, 8'd231,
        8'd234, 8'd238, 8'd241, 8'd243, 8'd246, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254,
        8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251, 8'd250, 8'd248, 8'd245,
        8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222, 8'd218, 8'd213, 8'd208,
        8'd203, 8'd198, 8'd193, 8'd187, 8'd181, 8'd176, 8'd170, 8'd164, 8'd158, 8'd151,
        8'd145, 8'd139, 8'd132, 8'd126, 8'd120, 8'd113, 8'd107, 8'd101, 8'd94,  8'd88,
        8'd82,  8'd76,  8'd71,  8'd65,  8'd59,  8'd54,  8'd49,  8'd44,  8'd39,  8'd35,
        8'd31,  8'd26,  8'd23,  8'd19,  8'd16,  8'd13,  8'd10,  8'd8,   8'd6,   8'd4,
        8'd2,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd3,
        8'd5,   8'd7,   8'd9,   8'd12,  8'd14,  8'd17,  8'd21,  8'd25,  8'd28,  8'd33,
        8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd68,  8'd73,  8'd79,  8'd85,
        8'd91,  8'd98,  8'd104, 8'd110, 8'd116, 8'd123
    };

    // palettes, packed r-g-b
    localparam logic [23:0] TWO_PAL [0:2][0:1] = '{
        '{24'hFF38B7, 24'hA321FF},
        '{24'hFF8B21, 24'h21BAFF},
        '{24'h0562FF, 24'h21FFD3}
    };
    localparam logic [23:0] THREE_PAL [0:1][0:2] = '{
        '{24'hFF12B0, 24'h0FC4FF, 24'hFFAB2B},
        '{24'hFF9CED, 24'hACF2FC, 24'hFFD38F}
    };

    typedef struct packed {
        logic        cmd;
        logic [31:0] time_ms;
        logic [7:0]  idx;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

// ----- hdl/lse_front.sv -----
// ----------------------------------------------------------------------------
// lse_front: request intake
// Two-entry queue that takes requests and hands them to the effect sequencer.
// ----------------------------------------------------------------------------
module lse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_command,
    input  logic [31:0]   i_time_ms,
    input  logic [7:0]    i_pixel_index,
    output logic          o_q_valid,
    output lse_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import lse_pkg::*;

    t_item      r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{cmd: i_command, time_ms: i_time_ms, idx: i_pixel_index};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- hdl/lse_div.sv -----
// ----------------------------------------------------------------------------
// lse_div: serial divider for the rainbow wheel position
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lse_pkg::t_div_req i_req,
    output lse_pkg::t_div_rsp o_rsp
);
    import lse_pkg::*;

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_dq;     // dividend shifts out, quotient shifts in
    logic [15:0] r_rem, r_dsr;
    logic [16:0] partial, diff;
    logic        qbit;

    always_comb begin
        partial = {r_rem, r_dq[31]};
        diff    = partial - {1'b0, r_dsr};
        qbit    = (partial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dq  <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[30:0], qbit};
            r_rem <= qbit ? diff[15:0] : partial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quot: r_dq, rem: r_rem};

endmodule

// ----- hdl/lse_back.sv -----
// ----------------------------------------------------------------------------
// lse_back: effect sequencer
// Holds configuration and animation state, runs frame and pixel requests
// through reciprocal-multiply steps and the wheel divider, and drives the
// result register.
// ----------------------------------------------------------------------------
module lse_back #(
    parameter int MAX_LEDS = lse_pkg::MAX_LEDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [8:0]     i_cfg_data,
    input  logic           i_q_valid,
    input  lse_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [23:0]    o_pixel_grb,
    output logic           o_last_pixel
);
    import lse_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_FRAME_MUL = 12'b000000000010,
        S_FRAME_REM = 12'b000000000100,
        S_FRAME_SEL = 12'b000000001000,
        S_FADE_NUM  = 12'b000000010000,
        S_FADE_DIV  = 12'b000000100000,
        S_PIX_DIV   = 12'b000001000000,
        S_PIX_COL   = 12'b000010000000,
        S_DIM_MUL   = 12'b000100000000,
        S_DIM_SCALE = 12'b001000000000,
        S_DIM_DIV   = 12'b010000000000,
        S_PUSH      = 12'b100000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0]  r_mode;
    logic [8:0]  r_bright, r_angle, r_led_count;
    // animation
    logic [7:0]  r_rb_off;
    logic        r_pol_phase;
    logic [31:0] r_pol_last;
    logic [6:0]  r_breath;
    logic [23:0] r_frame_color;
    // working registers
    t_item       r_item;
    logic [7:0]  r_q8;
    logic [23:0] r_col, r_acc, r_fa, r_fb;
    logic [10:0] r_fd, r_ff;
    logic [1:0]  r_ch;
    logic [16:0] r_prod;
    logic [57:0] r_fprod;
    logic [15:0] r_pos;
    logic [19:0] r_fnum;
    logic [15:0] r_dy;
    logic        r_last;
    logic        r_out_valid, r_out_last;
    logic [23:0] r_out_pix;

    t_div_req div_req;
    t_div_rsp div_rsp;

    lse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    function automatic logic [7:0] rgb_chan(input logic [23:0] c, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            2'd0:    v = c[23:16];
            2'd1:    v = c[15:8];
            default: v = c[7:0];
        endcase
        return v;
    endfunction

    // derived settings
    logic [8:0]  cnt_raw, count, bclamp, aclamp;
    logic [7:0]  fclamp;
    logic        is_two, is_three, out_free;
    logic [19:0] fade_num;
    logic [7:0]  fa_c, fb_c, rb_pos, rb_seg, breath_v;
    logic [23:0] pix_col;
    logic [1:0]  two_sel, cur, nxt;
    logic        three_sel;
    logic [15:0] pos, loc;
    logic [7:0]  dim_c;
    logic [27:0] frm_u;
    logic [29:0] frm_m;
    logic [9:0]  frm_d, frm_r;
    logic [19:0] frm_q;
    logic [15:0] frm_pos;
    logic [14:0] fade_y;
    logic [30:0] fade_p;
    logic [24:0] dim_x;
    logic [31:0] dim_p;

    always_comb begin
        cnt_raw  = (r_led_count == 9'd0) ? 9'd1 : r_led_count;
        count    = (32'(cnt_raw) > 32'(MAX_LEDS)) ? 9'(MAX_LEDS) : cnt_raw;
        bclamp   = (r_bright > BRIGHT_FULL) ? BRIGHT_FULL : r_bright;
        aclamp   = (r_angle > ANGLE_MAX) ? ANGLE_MAX : r_angle;
        fclamp   = (aclamp > ANGLE_ZERO) ? 8'(aclamp - ANGLE_ZERO) : 8'd0;
        is_two   = (r_mode == MODE_TWO_A) || (r_mode == MODE_TWO_B) || (r_mode == MODE_TWO_C);
        is_three = (r_mode == MODE_THREE_A) || (r_mode == MODE_THREE_B);
        two_sel  = 2'(r_mode - MODE_TWO_A);
        three_sel = 1'(r_mode - MODE_THREE_A);
        out_free = !r_out_valid || !i_stall;

        // frame period remainder: split off the power-of-two factor, then
        // reduce the odd part by reciprocal multiplication
        frm_u   = is_two ? r_item.time_ms[31:4] : {1'b0, r_item.time_ms[31:5]};
        frm_m   = is_two ? TWO_MOD_RECIP : THREE_MOD_RECIP;
        frm_d   = is_two ? TWO_MOD_D : THREE_MOD_D;
        frm_q   = r_fprod[57:38];
        frm_r   = 10'(frm_u - 28'(frm_q * frm_d));
        frm_pos = is_two ? {2'b00, frm_r, r_item.time_ms[3:0]}
                         : {1'b0, frm_r, r_item.time_ms[4:0]};

        // fade channel: a*(F-d) + b*d, never negative
        fa_c     = rgb_chan(r_fa, r_ch);
        fb_c     = rgb_chan(r_fb, r_ch);
        fade_num = 20'(fa_c * (r_ff - r_fd)) + 20'(fb_c * r_fd);
        // divide by 2000 or 1000: shift out 16 or 8, then divide by 125
        fade_y   = is_two ? r_fnum[18:4] : r_fnum[17:3];
        fade_p   = fade_y * FADE_RECIP;

        // divide by 57600: shift out 256, then divide by 225
        dim_x    = r_prod * fclamp;
        dim_p    = r_dy * DIM_RECIP;

        // frame position within the period
        pos = r_pos;
        if (pos < THREE_SEG) begin
            cur = 2'd0; nxt = 2'd1; loc = pos;
        end else if (pos < 16'(2 * THREE_SEG)) begin
            cur = 2'd1; nxt = 2'd2; loc = pos - THREE_SEG;
        end else begin
            cur = 2'd2; nxt = 2'd0; loc = pos - 16'(2 * THREE_SEG);
        end

        // pixel color
        rb_pos   = r_q8 + r_rb_off;
        breath_v = BREATH_TBL[r_breath];
        rb_seg   = 8'd0;
        case (r_mode)
            MODE_RED:     pix_col = 24'hFF0000;
            MODE_GREEN:   pix_col = 24'h00FF00;
            MODE_BLUE:    pix_col = 24'h0000FF;
            MODE_RAINBOW: begin
                if (rb_pos < 8'd85) begin
                    rb_seg  = rb_pos;
                    pix_col = {8'(rb_seg * 3), 8'(8'd255 - 8'(rb_seg * 3)), 8'd0};
                end else if (rb_pos < 8'd170) begin
                    rb_seg  = rb_pos - 8'd85;
                    pix_col = {8'(8'd255 - 8'(rb_seg * 3)), 8'd0, 8'(rb_seg * 3)};
                end else begin
                    rb_seg  = rb_pos - 8'd170;
                    pix_col = {8'd0, 8'(rb_seg * 3), 8'(8'd255 - 8'(rb_seg * 3))};
                end
            end
            MODE_POLICE: begin
                if (count == 9'd1) begin
                    pix_col = r_pol_phase ? 24'hFF0000 : 24'h0000FF;
                end else if ((9'(r_item.idx) < (count >> 1)) == r_pol_phase) begin
                    pix_col = 24'hFF0000;
                end else begin
                    pix_col = 24'h0000FF;
                end
            end
            MODE_BREATH: pix_col = {breath_v, breath_v, breath_v};
            MODE_TWO_A, MODE_TWO_B, MODE_TWO_C,
            MODE_THREE_A, MODE_THREE_B: pix_col = r_frame_color;
            default:      pix_col = 24'h000000;
        endcase

        // dimming order green, red, blue so the result packs g-r-b
        case (r_ch)
            2'd0:    dim_c = r_col[15:8];
            2'd1:    dim_c = r_col[23:16];
            default: dim_c = r_col[7:0];
        endcase

        div_req = '{start: 1'b0, dividend: 32'd0, divisor: 16'd1};
        o_q_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && i_q_item.cmd && r_mode == MODE_RAINBOW) begin
                    div_req = '{start: 1'b1, dividend: 32'({i_q_item.idx, 8'd0}),
                                divisor: 16'(count)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= MODE_RED;
            r_bright      <= BRIGHT_FULL;
            r_angle       <= ANGLE_MAX;
            r_led_count   <= 9'd8;
            r_rb_off      <= '0;
            r_pol_phase   <= 1'b0;
            r_pol_last    <= '0;
            r_breath      <= '0;
            r_frame_color <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_PUSH) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: begin
                        if (i_cfg_data[3:0] != r_mode) begin
                            r_mode        <= i_cfg_data[3:0];
                            r_rb_off      <= '0;
                            r_pol_phase   <= 1'b0;
                            r_pol_last    <= '0;
                            r_breath      <= '0;
                            r_frame_color <= '0;
                        end
                    end
                    CFG_BRIGHT: r_bright    <= i_cfg_data;
                    CFG_ANGLE:  r_angle     <= i_cfg_data;
                    CFG_COUNT:  r_led_count <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (!i_q_item.cmd) begin
                            if (r_mode == MODE_POLICE) begin
                                if ((i_q_item.time_ms - r_pol_last) > 32'd250) begin
                                    r_pol_last  <= i_q_item.time_ms;
                                    r_pol_phase <= ~r_pol_phase;
                                end
                            end else if (r_mode == MODE_BREATH) begin
                                r_breath <= (r_breath >= BREATH_LAST) ? 7'd0 : r_breath + 7'd1;
                            end else if (is_two || is_three) begin
                                r_state <= S_FRAME_MUL;
                            end
                        end else if (r_mode == MODE_RAINBOW) begin
                            r_state <= S_PIX_DIV;
                        end else begin
                            r_q8    <= 8'd0;
                            r_state <= S_PIX_COL;
                        end
                    end
                end
                S_FRAME_MUL: begin
                    r_fprod <= frm_u * frm_m;
                    r_state <= S_FRAME_REM;
                end
                S_FRAME_REM: begin
                    r_pos   <= frm_pos;
                    r_state <= S_FRAME_SEL;
                end
                S_FRAME_SEL: begin
                    r_ch <= 2'd0;
                    if (is_two) begin
                        r_ff <= 11'(TWO_FADE);
                        if (pos < TWO_HOLD) begin
                            r_frame_color <= TWO_PAL[two_sel][0];
                            r_state       <= S_IDLE;
                        end else if (pos < TWO_HOLD + TWO_FADE) begin
                            r_fa    <= TWO_PAL[two_sel][0];
                            r_fb    <= TWO_PAL[two_sel][1];
                            r_fd    <= 11'(pos - TWO_HOLD);
                            r_state <= S_FADE_NUM;
                        end else if (pos < 16'(2 * TWO_HOLD + TWO_FADE)) begin
                            r_frame_color <= TWO_PAL[two_sel][1];
                            r_state       <= S_IDLE;
                        end else begin
                            r_fa    <= TWO_PAL[two_sel][1];
                            r_fb    <= TWO_PAL[two_sel][0];
                            r_fd    <= 11'(pos - 16'(2 * TWO_HOLD + TWO_FADE));
                            r_state <= S_FADE_NUM;
                        end
                    end else begin
                        r_ff <= 11'(THREE_FADE);
                        if (loc < THREE_HOLD) begin
                            r_frame_color <= THREE_PAL[three_sel][cur];
                            r_state       <= S_IDLE;
                        end else begin
                            r_fa    <= THREE_PAL[three_sel][cur];
                            r_fb    <= THREE_PAL[three_sel][nxt];
                            r_fd    <= 11'(loc - THREE_HOLD);
                            r_state <= S_FADE_NUM;
                        end
                    end
                end
                S_FADE_NUM: begin
                    r_fnum  <= fade_num;
                    r_state <= S_FADE_DIV;
                end
                S_FADE_DIV: begin
                    r_acc <= {r_acc[15:0], fade_p[29:22]};
                    if (r_ch == 2'd2) begin
                        r_frame_color <= {r_acc[15:0], fade_p[29:22]};
                        r_state       <= S_IDLE;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_FADE_NUM;
                    end
                end
                S_PIX_DIV: begin
                    if (div_rsp.done) begin
                        r_q8    <= div_rsp.quot[7:0];
                        r_state <= S_PIX_COL;
                    end
                end
                S_PIX_COL: begin
                    r_col   <= pix_col;
                    r_last  <= (9'(r_item.idx) == count - 9'd1);
                    r_ch    <= 2'd0;
                    r_state <= S_DIM_MUL;
                end
                S_DIM_MUL: begin
                    r_prod  <= 17'(dim_c * bclamp);
                    r_state <= S_DIM_SCALE;
                end
                S_DIM_SCALE: begin
                    r_dy    <= dim_x[23:8];
                    r_state <= S_DIM_DIV;
                end
                S_DIM_DIV: begin
                    r_acc <= {r_acc[15:0], dim_p[31:24]};
                    if (r_ch == 2'd2) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_DIM_MUL;
                    end
                end
                S_PUSH: begin
                    // hold until the result register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_acc;
                        r_out_last  <= r_last;
                        if (r_mode == MODE_RAINBOW && r_last) r_rb_off <= r_rb_off + 8'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_grb  = r_out_pix;
    assign o_last_pixel = r_out_last;

endmodule

// ----- hdl/led_strip_effect_engine.sv -----
// ----------------------------------------------------------------------------
// led_strip_effect_engine: LED strip effect generator
// Frame-start and pixel requests in, one dimmed g-r-b pixel per pixel request.
//
//   channel   handshake            payload
//   input     i_valid / o_stall    i_command, i_time_ms, i_pixel_index
//   output    o_valid / i_stall    o_pixel_grb, o_last_pixel
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request at a time; constant divisions by reciprocal multiplication.
// Frame start: done in idle; period steps in two- and three-color modes, fade steps in a fade.
// Pixel: color, dim steps per channel, push; rainbow first runs the 32-bit wheel position divide.
// A two-entry queue takes requests while the sequencer works or the result
// waits. Reset (synchronous, active low) restores control, configuration and animation state.
// ----------------------------------------------------------------------------
module led_strip_effect_engine #(
    parameter int MAX_LEDS = lse_pkg::MAX_LEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_time_ms,
    input  logic [7:0]  i_pixel_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_pixel_grb,
    output logic        o_last_pixel,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    import lse_pkg::*;

    logic  q_valid, q_pop;
    t_item q_item;

    lse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_time_ms     (i_time_ms),
        .i_pixel_index (i_pixel_index),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    lse_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_grb  (o_pixel_grb),
        .o_last_pixel (o_last_pixel)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the LED strip effect engine
// Drives frame-start and pixel requests with random bursts and output stalls,
// predicts every dimmed pixel and compares it field by field in order.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
    logic [3:0]  mode;
    logic [8:0]  bright;
    logic [8:0]  angle;
    logic [8:0]  count;
    logic [7:0]  rb_offset;
    logic        pol_phase;
    logic [31:0] pol_toggle;
    logic [6:0]  br_step;
    logic [23:0] frame_rgb;
    logic [23:0] exp_grb [$];
    logic        exp_last [$];
    int          errors;

    function new();
        errors = 0;
        mode = lse_pkg::MODE_RED;
        bright = 9'd256;
        angle = 9'd450;
        count = 9'd8;
        clear_anim();
    endfunction

    function void clear_anim();
        rb_offset = 0;
        pol_phase = 0;
        pol_toggle = 0;
        br_step = 0;
        frame_rgb = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
        case (idx)
            lse_pkg::CFG_MODE: begin
                if (data[3:0] != mode) begin
                    mode = data[3:0];
                    clear_anim();
                end
            end
            lse_pkg::CFG_BRIGHT: bright = data;
            lse_pkg::CFG_ANGLE:  angle = data;
            default:             count = data;
        endcase
    endfunction

    function logic [7:0] fade_ch(int a, int b, int d, int f);
        int num;
        num = a * f + (b - a) * d;
        if (num < 0) num = 0;
        return 8'(num / f);
    endfunction

    function logic [23:0] fade_rgb(logic [23:0] x, logic [23:0] y, int d, int f);
        return {fade_ch(x[23:16], y[23:16], d, f), fade_ch(x[15:8], y[15:8], d, f),
                fade_ch(x[7:0], y[7:0], d, f)};
    endfunction

    function logic [7:0] dim(logic [7:0] c);
        longint b, a, f;
        b = (bright > 256) ? 256 : bright;
        a = (angle > 450) ? 450 : angle;
        f = (a > 225) ? a - 225 : 0;
        return 8'((c * b * f) / 57600);
    endfunction

    function void frame_start(logic [31:0] t);
        logic [23:0] p0, p1;
        int pos, cur, nxt, loc;
        if (mode == lse_pkg::MODE_POLICE) begin
            if (t - pol_toggle > 32'd250) begin
                pol_toggle = t;
                pol_phase = ~pol_phase;
            end
        end else if (mode == lse_pkg::MODE_BREATH) begin
            br_step = (br_step == lse_pkg::BREATH_LAST) ? 7'd0 : br_step + 7'd1;
        end else if (mode >= lse_pkg::MODE_TWO_A && mode <= lse_pkg::MODE_TWO_C) begin
            p0 = lse_pkg::TWO_PAL[mode - 6][0];
            p1 = lse_pkg::TWO_PAL[mode - 6][1];
            pos = t % 14000;
            if (pos < 5000) frame_rgb = p0;
            else if (pos < 7000) frame_rgb = fade_rgb(p0, p1, pos - 5000, 2000);
            else if (pos < 12000) frame_rgb = p1;
            else frame_rgb = fade_rgb(p1, p0, pos - 12000, 2000);
        end else if (mode == lse_pkg::MODE_THREE_A || mode == lse_pkg::MODE_THREE_B) begin
            pos = t % 12000;
            cur = pos / 4000;
            loc = pos % 4000;
            nxt = (cur == 2) ? 0 : cur + 1;
            p0 = lse_pkg::THREE_PAL[mode - 9][cur];
            p1 = lse_pkg::THREE_PAL[mode - 9][nxt];
            frame_rgb = (loc < 3000) ? p0 : fade_rgb(p0, p1, loc - 3000, 1000);
        end
    endfunction

    function logic [23:0] pixel_rgb(int idx, int cnt);
        int pos;
        logic [7:0] v;
        logic first;
        case (mode)
            lse_pkg::MODE_RED:   return 24'hFF0000;
            lse_pkg::MODE_GREEN: return 24'h00FF00;
            lse_pkg::MODE_BLUE:  return 24'h0000FF;
            lse_pkg::MODE_RAINBOW: begin
                pos = (idx * 256 / cnt + rb_offset) % 256;
                if (pos < 85) return {8'(pos * 3), 8'(255 - pos * 3), 8'd0};
                if (pos < 170) begin
                    pos -= 85;
                    return {8'(255 - pos * 3), 8'd0, 8'(pos * 3)};
                end
                pos -= 170;
                return {8'd0, 8'(pos * 3), 8'(255 - pos * 3)};
            end
            lse_pkg::MODE_POLICE: begin
                if (cnt == 1) return pol_phase ? 24'hFF0000 : 24'h0000FF;
                first = idx < cnt / 2;
                return (pol_phase == first) ? 24'hFF0000 : 24'h0000FF;
            end
            lse_pkg::MODE_BREATH: begin
                v = lse_pkg::BREATH_TBL[br_step];
                return {v, v, v};
            end
            lse_pkg::MODE_TWO_A, lse_pkg::MODE_TWO_B, lse_pkg::MODE_TWO_C,
            lse_pkg::MODE_THREE_A, lse_pkg::MODE_THREE_B: return frame_rgb;
            default: return 24'h0;
        endcase
    endfunction

    // note an accepted request and queue its pixel, if any
    function void note_request(logic cmd, logic [31:0] t, logic [7:0] idx);
        int cnt;
        logic last;
        logic [23:0] rgb;
        if (!cmd) begin
            frame_start(t);
            return;
        end
        cnt = count;
        if (cnt == 0) cnt = 1;
        if (cnt > 256) cnt = 256;
        last = (idx == cnt - 1);
        rgb = pixel_rgb(idx, cnt);
        exp_grb.push_back({dim(rgb[15:8]), dim(rgb[23:16]), dim(rgb[7:0])});
        exp_last.push_back(last);
        if (mode == lse_pkg::MODE_RAINBOW && last) rb_offset++;
    endfunction

    function void check_pixel(logic [23:0] grb, logic last);
        logic [23:0] eg;
        logic el;
        if (exp_grb.size() == 0) begin
            $display("%0t: unexpected pixel %h last %b", $time, grb, last);
            errors++;
            return;
        end
        eg = exp_grb.pop_front();
        el = exp_last.pop_front();
        if (grb !== eg) begin
            $display("%0t: pixel_grb expected %h actual %h", $time, eg, grb);
            errors++;
        end
        if (last !== el) begin
            $display("%0t: last_pixel expected %b actual %b", $time, el, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import lse_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        cmd = 0;
    logic [31:0] time_ms = 0;
    logic [7:0]  pix_idx = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [23:0] pixel_grb;
    logic        last_pixel;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = 0;
    logic [8:0]  cfg_data = 0;
    logic        driving = 1;

    pixel_scoreboard sb = new();
    logic [31:0] clock_ms;
    logic [8:0]  cur_count;

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    led_strip_effect_engine dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_command(cmd), .i_time_ms(time_ms), .i_pixel_index(pix_idx),
        .o_valid(out_valid), .i_stall(out_stall), .o_pixel_grb(pixel_grb),
        .o_last_pixel(last_pixel), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_pixel(pixel_grb, last_pixel);
    end

    // receiver stall pattern: quiet stretches and busy stretches
    always @(negedge clk) begin
        if (!driving) out_stall <= 0;
        else if ($urandom_range(0, 99) < 2) out_stall <= 0;
        else if (($time / 8000) % 3 == 0) out_stall <= 0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic send(logic c, logic [31:0] t, logic [7:0] idx);
        @(negedge clk);
        in_valid <= 1;
        cmd <= c;
        time_ms <= t;
        pix_idx <= idx;
        do @(posedge clk); while (in_stall);
        sb.note_request(c, t, idx);
    endtask

    // drop valid and wait a random gap, ending a burst
    task automatic gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.exp_grb.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [8:0] data);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_COUNT) cur_count = data;
    endtask

    task automatic burst(int n);
        int k, eff, len;
        len = 0;
        for (k = 0; k < n; k++) begin
            eff = (cur_count == 0) ? 1 : (cur_count > 256 ? 256 : cur_count);
            if ($urandom_range(0, 9) == 0) begin
                send(1'b0, $urandom(), 8'($urandom()));
            end else if ($urandom_range(0, 5) == 0) begin
                clock_ms += $urandom_range(0, 3000);
                send(1'b0, clock_ms, 8'($urandom()));
            end else begin
                send(1'b1, $urandom(), 8'($urandom_range(0, 9) == 0 ? $urandom() : k % eff));
            end
            if (len == 0) begin
                len = $urandom_range(1, 20);
                gap();
            end else len--;
        end
    endtask

    initial begin
        int p, v;
        clock_ms = 0;
        cur_count = 8;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: reset defaults, extremes of each field
        send(1, 0, 0);
        send(1, 32'hFFFFFFFF, 8'hFF);
        send(1, 0, 7);
        send(0, 32'hFFFFFFFF, 0);
        drain();
        write_cfg(CFG_COUNT, 1);
        write_cfg(CFG_MODE, MODE_POLICE);
        send(1, 0, 0);
        send(0, 251, 0);
        send(1, 0, 0);
        send(1, 0, 200);
        send(0, 400, 0);
        send(0, 600, 0);
        send(1, 0, 0);
        drain();
        write_cfg(CFG_COUNT, 0);
        write_cfg(CFG_MODE, MODE_RAINBOW);
        send(1, 0, 0);
        send(1, 0, 0);
        drain();
        write_cfg(CFG_MODE, MODE_RAINBOW);
        send(1, 0, 5);
        drain();
        write_cfg(CFG_MODE, MODE_TWO_A);
        send(1, 0, 1);
        send(0, 6000, 0);
        send(1, 0, 1);
        drain();
        write_cfg(CFG_MODE, 4'd15);
        send(0, 1, 0);
        send(1, 0, 3);
        drain();

        for (p = 0; p < 40; p++) begin
            v = $urandom_range(0, 5);
            write_cfg(CFG_MODE, 9'(v == 0 ? $urandom_range(11, 15) : $urandom_range(0, 10)));
            v = $urandom_range(0, 5);
            write_cfg(CFG_BRIGHT, 9'(v == 0 ? 256 : v == 1 ? 0 : v == 2 ? 511 : $urandom()));
            v = $urandom_range(0, 5);
            write_cfg(CFG_ANGLE, 9'(v == 0 ? 450 : v == 1 ? 225 : v == 2 ? 511 : $urandom()));
            v = $urandom_range(0, 5);
            write_cfg(CFG_COUNT, 9'(v == 0 ? 256 : v == 1 ? 1 : v == 2 ? 0 :
                      v == 3 ? 511 : $urandom_range(2, 40)));
            burst(43);
            drain();
        end
        driving = 0;
        if (sb.errors == 0 && sb.exp_grb.size() == 0) begin
            $display("led_strip_effect_engine regression: pass");
        end else begin
            $display("led_strip_effect_engine regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("led_strip_effect_engine regression: fail");
        $finish;
    end
endmodule
